[rtl/mtem_pkg.sv]
// Shared widths, register codes and control types of the multi-tap echo mixer.
// Depends on nothing; every other file imports it.
package mtem_pkg;

  localparam int SampleW  = 16;
  localparam int GainW    = 16;
  localparam int ChanW    = 1;
  localparam int PosW     = 12;
  localparam int AddrW    = ChanW + PosW;
  localparam int MemDepth = 2 ** AddrW;
  localparam int MaxDelay = 2 ** PosW;
  localparam int DelayW   = 13;
  localparam int NumTaps  = 4;
  localparam int TapW     = 2;
  localparam int ChanCntW = 2;
  localparam int TapCntW  = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 29;
  localparam int MulW     = 32;
  localparam int AccW     = 35;
  localparam int ProdW    = AccW + GainW + 1;
  localparam int FracBits = 30;
  localparam int QW       = ProdW - FracBits;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IN_GAIN  = 3'd0,
    REG_OUT_GAIN = 3'd1,
    REG_CHAN_CNT = 3'd2,
    REG_TAP_CNT  = 3'd3,
    REG_TAP_0    = 3'd4,
    REG_TAP_1    = 3'd5,
    REG_TAP_2    = 3'd6,
    REG_TAP_3    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]                in_gain;
    logic [GainW-1:0]                mix_gain;
    logic                            single_chan;
    logic [TapW-1:0]                 taps_m1;
    logic [NumTaps-1:0][PosW-1:0]    delay;
    logic [NumTaps-1:0][GainW-1:0]   decay;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             rd_issue;
    logic [TapW-1:0]  tap_sel;
    logic             commit;
    logic             out_load;
    logic             clr_wr;
    logic [AddrW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } sts_t;

endpackage

[rtl/mtem_if.sv]
// Handshake interfaces for the sample input, result output and register write channels.
// Depends on mtem_pkg for the payload widths.
interface mtem_in_if import mtem_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ChanW-1:0]          channel;
  logic signed [SampleW-1:0] sample_in;

  modport source (output valid, channel, sample_in, input ready);
  modport sink (input valid, channel, sample_in, output ready);
endinterface

interface mtem_out_if import mtem_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ChanW-1:0]          out_channel;
  logic signed [SampleW-1:0] sample_out;

  modport source (output valid, out_channel, sample_out, input ready);
  modport sink (input valid, out_channel, sample_out, output ready);
endinterface

interface mtem_cfg_if import mtem_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/multi_tap_echo_mixer.sv]
// Top level of the multi-tap echo mixer: configuration, controller and datapath.
// Depends on mtem_pkg, mtem_if, mtem_cfg, mtem_ctrl and mtem_dp.
//
//   Port      Dir  Beat carries
//   sample_i  in   channel, sample_in
//   result_o  out  out_channel, sample_out
//   cfg_i     in   index, data (register write, always ready)
//
// From acceptance, a sample passes through one ring read per active tap, a wait
// until the tap accumulation drains, scaling, and rounding into the result register.
// After reset all 8192 ring entries are cleared before the first beat is taken.
// A result waits in the output register; the next sample is accepted meanwhile,
// and only its own result handoff stalls until that register is free.
module multi_tap_echo_mixer import mtem_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  mtem_in_if.sink     sample_i,
  mtem_out_if.source  result_o,
  mtem_cfg_if.sink    cfg_i
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  mtem_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mtem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .taps_m1_i  (cfg.taps_m1),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtem_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_channel_i  (sample_i.channel),
    .in_sample_i   (sample_i.sample_in),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .out_channel_o (result_o.out_channel),
    .out_sample_o  (result_o.sample_out)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("sample accepted while another is in flight");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(cmd.out_load))
    else $error("result valid rose without a result load");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !sts.busy)
    else $error("scaling started before all taps were accumulated");

endmodule

[rtl/mtem_cfg.sv]
// Configuration registers and the decoding of their fields into working values.
// Depends on mtem_pkg and mtem_cfg_if.
module mtem_cfg import mtem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mtem_cfg_if.sink cfg_i,
  output cfg_t     cfg_o
);

  localparam logic [GainW-1:0]    InGainRst  = 16'd19661;
  localparam logic [GainW-1:0]    OutGainRst = 16'd9830;
  localparam logic [ChanCntW-1:0] ChanCntRst = 2'd1;
  localparam logic [TapCntW-1:0]  TapCntRst  = 3'd1;
  localparam logic [CfgDataW-1:0] Tap0Rst    = 29'd134221824;

  logic [GainW-1:0]                   in_gain_q;
  logic [GainW-1:0]                   mix_gain_q;
  logic [ChanCntW-1:0]                chan_cnt_q;
  logic [TapCntW-1:0]                 tap_cnt_q;
  logic [NumTaps-1:0][CfgDataW-1:0]   tap_word_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_gain_q  <= InGainRst;
      mix_gain_q <= OutGainRst;
      chan_cnt_q <= ChanCntRst;
      tap_cnt_q  <= TapCntRst;
      tap_word_q[0] <= Tap0Rst;
      tap_word_q[1] <= '0;
      tap_word_q[2] <= '0;
      tap_word_q[3] <= '0;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_IN_GAIN:  in_gain_q  <= cfg_i.data[GainW-1:0];
        REG_OUT_GAIN: mix_gain_q <= cfg_i.data[GainW-1:0];
        REG_CHAN_CNT: chan_cnt_q <= cfg_i.data[ChanCntW-1:0];
        REG_TAP_CNT:  tap_cnt_q  <= cfg_i.data[TapCntW-1:0];
        REG_TAP_0:    tap_word_q[0] <= cfg_i.data;
        REG_TAP_1:    tap_word_q[1] <= cfg_i.data;
        REG_TAP_2:    tap_word_q[2] <= cfg_i.data;
        REG_TAP_3:    tap_word_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [DelayW-1:0] dly;
    cfg_o.in_gain     = in_gain_q;
    cfg_o.mix_gain    = mix_gain_q;
    cfg_o.single_chan = (chan_cnt_q <= 2'd1);
    if (tap_cnt_q == '0) begin
      cfg_o.taps_m1 = '0;
    end else if (tap_cnt_q >= TapCntW'(NumTaps)) begin
      cfg_o.taps_m1 = TapW'(NumTaps - 1);
    end else begin
      cfg_o.taps_m1 = TapW'(tap_cnt_q - 3'd1);
    end
    // A delay of zero or of the full ring length both read the oldest entry.
    for (int t = 0; t < NumTaps; t++) begin
      dly = tap_word_q[t][DelayW-1:0];
      cfg_o.delay[t] = (dly > DelayW'(MaxDelay)) ? '0 : dly[PosW-1:0];
      cfg_o.decay[t] = tap_word_q[t][DelayW +: GainW];
    end
  end

endmodule

[rtl/mtem_ctrl.sv]
// Controller state machine: ring clearing after reset, tap read sequencing and result handoff.
// Depends on mtem_pkg for the command and status types.
module mtem_ctrl import mtem_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [TapW-1:0] taps_m1_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_WAIT  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_ROUND = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [TapW-1:0]  tap_q, tap_d;
  logic [AddrW-1:0] clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      tap_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    tap_d        = tap_q;
    clr_d        = clr_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.tap_sel  = tap_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          tap_d = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (tap_q == taps_m1_i) begin
          state_d = ST_WAIT;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (!sts_i.busy) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.commit = 1'b1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/mtem_dp.sv]
// Datapath: delay ring memory, tap multiply-accumulate, output scaling, rounding and result register.
// Depends on mtem_pkg for widths and the configuration, command and status types.
module mtem_dp import mtem_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic [ChanW-1:0]          in_channel_i,
  input  logic signed [SampleW-1:0] in_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ChanW-1:0]          out_channel_o,
  output logic signed [SampleW-1:0] out_sample_o
);

  localparam logic signed [QW-1:0] QMax = QW'(SampleMax);
  localparam logic signed [QW-1:0] QMin = QW'(SampleMin);

  logic signed [SampleW-1:0] mem_q [MemDepth];

  logic signed [SampleW-1:0]     x_q;
  logic [ChanW-1:0]              ch_q;
  logic [PosW-1:0]               pos_q;
  logic signed [SampleW-1:0]     rd_data_q;
  logic [GainW-1:0]              dec_q;
  logic                          rd_vld_q;
  logic                          mul_vld_q;
  logic signed [MulW-1:0]        tprod_q;
  logic signed [AccW-1:0]        acc_q;
  logic signed [ProdW-1:0]       scl_q;
  logic                          out_valid_q;
  logic [ChanW-1:0]              out_ch_q;
  logic signed [SampleW-1:0]     out_smp_q;

  logic                          mem_we;
  logic [AddrW-1:0]              mem_waddr;
  logic signed [SampleW-1:0]     mem_wdata;
  logic [AddrW-1:0]              rd_addr;
  logic [PosW-1:0]               rd_pos;
  logic signed [SampleW+GainW:0] dry_mul;
  logic signed [SampleW+GainW:0] tap_mul;
  logic signed [ProdW-1:0]       scl_mul;
  logic                          rnd;
  logic signed [QW-1:0]          q;
  logic signed [SampleW-1:0]     sat;

  assign mem_we    = cmd_i.clr_wr | cmd_i.commit;
  assign mem_waddr = cmd_i.clr_wr ? cmd_i.clr_addr : {ch_q, pos_q};
  assign mem_wdata = cmd_i.clr_wr ? '0 : x_q;
  assign rd_pos    = pos_q - cfg_i.delay[cmd_i.tap_sel];
  assign rd_addr   = {ch_q, rd_pos};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign dry_mul = in_sample_i * $signed({1'b0, cfg_i.in_gain});
  assign tap_mul = rd_data_q * $signed({1'b0, dec_q});
  assign scl_mul = acc_q * $signed({1'b0, cfg_i.mix_gain});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= in_sample_i;
      ch_q  <= in_channel_i;
      acc_q <= AccW'(dry_mul);
    end else if (mul_vld_q) begin
      acc_q <= acc_q + AccW'(tprod_q);
    end
    if (cmd_i.rd_issue) begin
      dec_q <= cfg_i.decay[cmd_i.tap_sel];
    end
    tprod_q <= tap_mul[MulW-1:0];
    if (cmd_i.commit) begin
      scl_q <= scl_mul;
    end
    if (cmd_i.out_load) begin
      out_ch_q  <= ch_q;
      out_smp_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rd_vld_q    <= 1'b0;
      mul_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_issue;
      mul_vld_q <= rd_vld_q;
      if (cmd_i.commit && (cfg_i.single_chan || ch_q == '1)) begin
        pos_q <= pos_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The arithmetic shift rounds toward minus infinity, so a negative value with
  // a nonzero fraction is moved up by one to truncate toward zero.
  always_comb begin
    rnd = scl_q[ProdW-1] && (scl_q[FracBits-1:0] != '0);
    q   = $signed(scl_q[ProdW-1:FracBits]) + $signed({{(QW-1){1'b0}}, rnd});
    if (q > QMax) begin
      sat = SampleMax;
    end else if (q < QMin) begin
      sat = SampleMin;
    end else begin
      sat = q[SampleW-1:0];
    end
  end

  assign sts_o.busy     = rd_vld_q | mul_vld_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign out_sample_o  = out_smp_q;

endmodule
